[sv/sae_pkg.sv]
// ----------------------------------------------------------------------------
// sae_pkg
// Shared types, codes and microprogram ROM of the stack arithmetic evaluator.
// ----------------------------------------------------------------------------
package sae_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int FRAC_W          = 16;
    localparam int DEPTH_W         = 9;
    localparam int QUO_W           = DATA_W + FRAC_W;
    localparam int DIV_ITER        = QUO_W / 2;
    localparam int DIV_CNT_W       = $clog2(DIV_ITER);
    localparam int UADDR_W         = 5;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [2:0] KIND_RET  = 3'd0;
    localparam logic [2:0] KIND_PUSH = 3'd1;
    localparam logic [2:0] KIND_NEG  = 3'd2;
    localparam logic [2:0] KIND_ADD  = 3'd3;
    localparam logic [2:0] KIND_SUB  = 3'd4;
    localparam logic [2:0] KIND_MUL  = 3'd5;
    localparam logic [2:0] KIND_DIV  = 3'd6;

    typedef enum logic [1:0] {
        ST_OK,
        ST_UNDER,
        ST_OVER,
        ST_DIVZERO
    } status_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_NEG,
        ACT_WB1,
        ACT_RDA,
        ACT_ADD,
        ACT_SUB,
        ACT_MUL,
        ACT_MULSAT,
        ACT_DIVGO,
        ACT_DIVRES,
        ACT_WB2
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_FULL,
        COND_EMPTY,
        COND_LT2,
        COND_BZERO,
        COND_DIVBUSY
    } cond_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        act_t                act;
        cond_t               cond;
        logic [UADDR_W-1:0]  target;
        logic                emit;
        status_t             status;
        logic                fin;
    } uword_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic lt2;
        logic bzero;
        logic div_busy;
        logic out_blocked;
    } seq_flags_t;

    typedef struct packed {
        uword_t uw;
        logic   fire;
        logic   idle;
    } seq_ctl_t;

    localparam logic [UADDR_W-1:0] U_RET   = UADDR_W'(0);
    localparam logic [UADDR_W-1:0] U_OK    = UADDR_W'(1);
    localparam logic [UADDR_W-1:0] U_UND   = UADDR_W'(2);
    localparam logic [UADDR_W-1:0] U_OVF   = UADDR_W'(3);
    localparam logic [UADDR_W-1:0] U_DVZ   = UADDR_W'(4);
    localparam logic [UADDR_W-1:0] U_PUSH  = UADDR_W'(5);
    localparam logic [UADDR_W-1:0] U_NEG   = UADDR_W'(7);
    localparam logic [UADDR_W-1:0] U_ADD   = UADDR_W'(10);
    localparam logic [UADDR_W-1:0] U_SUB   = UADDR_W'(13);
    localparam logic [UADDR_W-1:0] U_MUL   = UADDR_W'(16);
    localparam logic [UADDR_W-1:0] U_DIV   = UADDR_W'(20);
    localparam logic [UADDR_W-1:0] U_DWAIT = UADDR_W'(23);
    localparam logic [UADDR_W-1:0] U_WB2   = UADDR_W'(25);

    function automatic uword_t mk_uword(
        input act_t               act,
        input cond_t              cond,
        input logic [UADDR_W-1:0] target,
        input logic               emit,
        input status_t            status,
        input logic               fin
    );
        uword_t w;
        w.act    = act;
        w.cond   = cond;
        w.target = target;
        w.emit   = emit;
        w.status = status;
        w.fin    = fin;
        return w;
    endfunction

    function automatic logic [UADDR_W-1:0] entry_addr(input logic [2:0] kind);
        logic [UADDR_W-1:0] a;
        case (kind)
            KIND_RET:  a = U_RET;
            KIND_PUSH: a = U_PUSH;
            KIND_NEG:  a = U_NEG;
            KIND_ADD:  a = U_ADD;
            KIND_SUB:  a = U_SUB;
            KIND_MUL:  a = U_MUL;
            KIND_DIV:  a = U_DIV;
            default:   a = U_OK;
        endcase
        return a;
    endfunction

    function automatic uword_t ucode(input logic [UADDR_W-1:0] addr);
        uword_t w;
        case (addr)
            U_RET:                w = mk_uword(ACT_NONE, COND_NEVER, U_RET, 1'b1, ST_OK, 1'b1);
            U_OK:                 w = mk_uword(ACT_NONE, COND_NEVER, U_OK, 1'b1, ST_OK, 1'b0);
            U_UND:                w = mk_uword(ACT_NONE, COND_NEVER, U_OK, 1'b1, ST_UNDER, 1'b0);
            U_OVF:                w = mk_uword(ACT_NONE, COND_NEVER, U_OK, 1'b1, ST_OVER, 1'b0);
            U_DVZ:                w = mk_uword(ACT_NONE, COND_NEVER, U_OK, 1'b1, ST_DIVZERO, 1'b0);
            U_PUSH:               w = mk_uword(ACT_NONE, COND_FULL, U_OVF, 1'b0, ST_OK, 1'b0);
            U_PUSH + UADDR_W'(1): w = mk_uword(ACT_PUSH, COND_ALWAYS, U_OK, 1'b0, ST_OK, 1'b0);
            U_NEG:                w = mk_uword(ACT_NONE, COND_EMPTY, U_UND, 1'b0, ST_OK, 1'b0);
            U_NEG + UADDR_W'(1):  w = mk_uword(ACT_NEG, COND_NEVER, U_OK, 1'b0, ST_OK, 1'b0);
            U_NEG + UADDR_W'(2):  w = mk_uword(ACT_WB1, COND_ALWAYS, U_OK, 1'b0, ST_OK, 1'b0);
            U_ADD:                w = mk_uword(ACT_NONE, COND_LT2, U_UND, 1'b0, ST_OK, 1'b0);
            U_ADD + UADDR_W'(1):  w = mk_uword(ACT_RDA, COND_NEVER, U_OK, 1'b0, ST_OK, 1'b0);
            U_ADD + UADDR_W'(2):  w = mk_uword(ACT_ADD, COND_ALWAYS, U_WB2, 1'b0, ST_OK, 1'b0);
            U_SUB:                w = mk_uword(ACT_NONE, COND_LT2, U_UND, 1'b0, ST_OK, 1'b0);
            U_SUB + UADDR_W'(1):  w = mk_uword(ACT_RDA, COND_NEVER, U_OK, 1'b0, ST_OK, 1'b0);
            U_SUB + UADDR_W'(2):  w = mk_uword(ACT_SUB, COND_ALWAYS, U_WB2, 1'b0, ST_OK, 1'b0);
            U_MUL:                w = mk_uword(ACT_NONE, COND_LT2, U_UND, 1'b0, ST_OK, 1'b0);
            U_MUL + UADDR_W'(1):  w = mk_uword(ACT_RDA, COND_NEVER, U_OK, 1'b0, ST_OK, 1'b0);
            U_MUL + UADDR_W'(2):  w = mk_uword(ACT_MUL, COND_NEVER, U_OK, 1'b0, ST_OK, 1'b0);
            U_MUL + UADDR_W'(3):  w = mk_uword(ACT_MULSAT, COND_ALWAYS, U_WB2, 1'b0, ST_OK, 1'b0);
            U_DIV:                w = mk_uword(ACT_NONE, COND_LT2, U_UND, 1'b0, ST_OK, 1'b0);
            U_DIV + UADDR_W'(1):  w = mk_uword(ACT_RDA, COND_BZERO, U_DVZ, 1'b0, ST_OK, 1'b0);
            U_DIV + UADDR_W'(2):  w = mk_uword(ACT_DIVGO, COND_NEVER, U_OK, 1'b0, ST_OK, 1'b0);
            U_DWAIT:              w = mk_uword(ACT_NONE, COND_DIVBUSY, U_DWAIT, 1'b0, ST_OK, 1'b0);
            U_DWAIT + UADDR_W'(1): w = mk_uword(ACT_DIVRES, COND_ALWAYS, U_WB2, 1'b0, ST_OK, 1'b0);
            U_WB2:                w = mk_uword(ACT_WB2, COND_ALWAYS, U_OK, 1'b0, ST_OK, 1'b0);
            default:              w = mk_uword(ACT_NONE, COND_ALWAYS, U_OK, 1'b0, ST_OK, 1'b0);
        endcase
        return w;
    endfunction

endpackage

[sv/sae_divider.sv]
// ----------------------------------------------------------------------------
// sae_divider
// Signed Q16.16 divider: restoring division on magnitudes, two quotient bits
// per cycle, result truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module sae_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sae_pkg::DATA_W-1:0] dividend,
    input  logic [sae_pkg::DATA_W-1:0] divisor,
    output logic                       busy,
    output logic [sae_pkg::DATA_W-1:0] quotient
);

    logic                          busy_reg, busy_next;
    logic [sae_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [sae_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [sae_pkg::DATA_W-1:0]    den_reg, den_next;
    logic [sae_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic                          neg_reg, neg_next;

    logic [sae_pkg::DATA_W-1:0] mag_a;
    logic [sae_pkg::DATA_W-1:0] mag_b;
    logic [sae_pkg::DATA_W:0]   r1;
    logic [sae_pkg::DATA_W:0]   r2;
    logic                       ge1;
    logic                       ge2;
    logic [sae_pkg::DATA_W-1:0] rem1;
    logic [sae_pkg::DATA_W-1:0] rem2;

    always_comb
    begin
        mag_a = dividend[sae_pkg::DATA_W-1] ? sae_pkg::DATA_W'(0) - dividend : dividend;
        mag_b = divisor[sae_pkg::DATA_W-1] ? sae_pkg::DATA_W'(0) - divisor : divisor;

        r1   = {rem_reg, quo_reg[sae_pkg::QUO_W-1]};
        ge1  = r1 >= {1'b0, den_reg};
        rem1 = ge1 ? sae_pkg::DATA_W'(r1 - {1'b0, den_reg}) : sae_pkg::DATA_W'(r1);
        r2   = {rem1, quo_reg[sae_pkg::QUO_W-2]};
        ge2  = r2 >= {1'b0, den_reg};
        rem2 = ge2 ? sae_pkg::DATA_W'(r2 - {1'b0, den_reg}) : sae_pkg::DATA_W'(r2);
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = mag_b;
            quo_next  = {mag_a, {sae_pkg::FRAC_W{1'b0}}};
            neg_next  = dividend[sae_pkg::DATA_W-1] ^ divisor[sae_pkg::DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_next = rem2;
            quo_next = {quo_reg[sae_pkg::QUO_W-3:0], ge1, ge2};
            cnt_next = cnt_reg + sae_pkg::DIV_CNT_W'(1);
            if (cnt_reg == sae_pkg::DIV_CNT_W'(sae_pkg::DIV_ITER - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg[sae_pkg::QUO_W-1:sae_pkg::DATA_W-1] != '0)
            begin
                quotient = sae_pkg::VAL_MAX;
            end
            else
            begin
                quotient = quo_reg[sae_pkg::DATA_W-1:0];
            end
        end
        else
        begin
            if (quo_reg > sae_pkg::QUO_W'({1'b1, {(sae_pkg::DATA_W-1){1'b0}}}))
            begin
                quotient = sae_pkg::VAL_MIN;
            end
            else
            begin
                quotient = sae_pkg::DATA_W'(0) - quo_reg[sae_pkg::DATA_W-1:0];
            end
        end
    end

    assign busy = busy_reg;

endmodule

[sv/sae_sequencer.sv]
// ----------------------------------------------------------------------------
// sae_sequencer
// Microprogram sequencer: dispatches on the instruction kind, steps through
// the control ROM and takes conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module sae_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          kind,
    input  sae_pkg::seq_flags_t flags,
    output sae_pkg::seq_ctl_t   ctl
);

    sae_pkg::seq_state_t           state_reg, state_next;
    logic [sae_pkg::UADDR_W-1:0]   pc_reg, pc_next;
    sae_pkg::uword_t               uw;
    logic                          cond_hit;
    logic                          fire;

    assign uw   = sae_pkg::ucode(pc_reg);
    assign fire = (state_reg == sae_pkg::SEQ_RUN) && !(uw.emit && flags.out_blocked);

    always_comb
    begin
        case (uw.cond)
            sae_pkg::COND_NEVER:   cond_hit = 1'b0;
            sae_pkg::COND_ALWAYS:  cond_hit = 1'b1;
            sae_pkg::COND_FULL:    cond_hit = flags.full;
            sae_pkg::COND_EMPTY:   cond_hit = flags.empty;
            sae_pkg::COND_LT2:     cond_hit = flags.lt2;
            sae_pkg::COND_BZERO:   cond_hit = flags.bzero;
            sae_pkg::COND_DIVBUSY: cond_hit = flags.div_busy;
            default:               cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            sae_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    state_next = sae_pkg::SEQ_RUN;
                    pc_next    = sae_pkg::entry_addr(kind);
                end
            end
            sae_pkg::SEQ_RUN:
            begin
                if (fire)
                begin
                    if (uw.emit)
                    begin
                        state_next = sae_pkg::SEQ_IDLE;
                    end
                    else if (cond_hit)
                    begin
                        pc_next = uw.target;
                    end
                    else
                    begin
                        pc_next = pc_reg + sae_pkg::UADDR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = sae_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sae_pkg::SEQ_IDLE;
            pc_reg    <= sae_pkg::U_RET;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        ctl.uw   = uw;
        ctl.fire = fire;
        ctl.idle = (state_reg == sae_pkg::SEQ_IDLE);
    end

endmodule

[sv/stack_arith_evaluator_core.sv]
// ----------------------------------------------------------------------------
// stack_arith_evaluator_core
// Each instruction kind runs its own microprogram from the control ROM and
// ends with one result transfer; divide waits on the divider, which produces
// its quotient two bits at a time, and faults end early with a fault status.
// One item at a time: s_tready rises with the result, so a new item is taken
// only once the last one is through, and later while a result waits.
// Reset clears the stack count and all control; stack memory is not cleared.
// ----------------------------------------------------------------------------
module stack_arith_evaluator_core
#(
    parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // constant_value[31:0]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // top_value[31:0], depth[40:32], status[42:41], zero
    output logic        m_tlast
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = sae_pkg::DATA_W;

    sae_pkg::seq_flags_t flags;
    sae_pkg::seq_ctl_t   ctl;
    sae_pkg::act_t       act;

    logic                in_fire;
    logic [CW-1:0]       count_reg, count_next;
    logic [DW-1:0]       top_reg, top_next;
    logic [DW-1:0]       res_reg, res_next;
    logic [DW-1:0]       cval_reg, cval_next;
    logic signed [2*DW-1:0] prod_reg, prod_next;
    logic [DW-1:0]       rd_data_reg;

    logic                out_valid_reg, out_valid_next;
    logic [DW-1:0]       out_top_reg, out_top_next;
    logic [sae_pkg::DEPTH_W-1:0] out_depth_reg, out_depth_next;
    sae_pkg::status_t    out_status_reg, out_status_next;
    logic                out_fin_reg, out_fin_next;

    logic [DW-1:0] stack_mem [STACK_DEPTH];
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [AW-1:0] addr_push;
    logic [AW-1:0] addr_top;
    logic [AW-1:0] addr_low;

    logic          div_start;
    logic          div_busy;
    logic [DW-1:0] div_q;
    logic [DW:0]   sum33;
    logic [DW:0]   diff33;
    logic          do_emit;

    function automatic logic [DW-1:0] sat33(input logic [DW:0] v);
        logic [DW-1:0] r;
        if (v[DW] != v[DW-1])
        begin
            r = v[DW] ? sae_pkg::VAL_MIN : sae_pkg::VAL_MAX;
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    assign in_fire  = s_tvalid && ctl.idle;
    assign s_tready = ctl.idle;
    assign act      = ctl.fire ? ctl.uw.act : sae_pkg::ACT_NONE;
    assign do_emit  = ctl.fire && ctl.uw.emit;

    always_comb
    begin
        flags.full        = (count_reg == CW'(STACK_DEPTH));
        flags.empty       = (count_reg == '0);
        flags.lt2         = (count_reg < CW'(2));
        flags.bzero       = (top_reg == '0);
        flags.div_busy    = div_busy;
        flags.out_blocked = out_valid_reg && !m_tready;
    end

    sae_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_fire),
        .kind  (s_tuser),
        .flags (flags),
        .ctl   (ctl)
    );

    assign div_start = (act == sae_pkg::ACT_DIVGO);

    sae_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rd_data_reg),
        .divisor  (top_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign addr_push = AW'(count_reg);
    assign addr_top  = AW'(count_reg - CW'(1));
    assign addr_low  = AW'(count_reg - CW'(2));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_push;
        mem_wdata = cval_reg;
        mem_re    = (act == sae_pkg::ACT_RDA);
        case (act)
            sae_pkg::ACT_PUSH:
            begin
                mem_we = 1'b1;
            end
            sae_pkg::ACT_WB1:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_top;
                mem_wdata = res_reg;
            end
            sae_pkg::ACT_WB2:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_low;
                mem_wdata = res_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[addr_low];
        end
    end

    assign sum33  = {rd_data_reg[DW-1], rd_data_reg} + {top_reg[DW-1], top_reg};
    assign diff33 = {rd_data_reg[DW-1], rd_data_reg} - {top_reg[DW-1], top_reg};

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        prod_next  = prod_reg;
        cval_next  = in_fire ? s_tdata : cval_reg;
        case (act)
            sae_pkg::ACT_PUSH:
            begin
                count_next = count_reg + CW'(1);
                top_next   = cval_reg;
            end
            sae_pkg::ACT_NEG:
            begin
                res_next = (top_reg == sae_pkg::VAL_MIN) ? sae_pkg::VAL_MAX
                                                         : DW'(0) - top_reg;
            end
            sae_pkg::ACT_WB1:
            begin
                top_next = res_reg;
            end
            sae_pkg::ACT_ADD:
            begin
                res_next = sat33(sum33);
            end
            sae_pkg::ACT_SUB:
            begin
                res_next = sat33(diff33);
            end
            sae_pkg::ACT_MUL:
            begin
                prod_next = $signed(rd_data_reg) * $signed(top_reg);
            end
            sae_pkg::ACT_MULSAT:
            begin
                if (prod_reg[2*DW-1:DW+sae_pkg::FRAC_W-1]
                    == {(DW-sae_pkg::FRAC_W+1){prod_reg[2*DW-1]}})
                begin
                    res_next = prod_reg[DW+sae_pkg::FRAC_W-1:sae_pkg::FRAC_W];
                end
                else
                begin
                    res_next = prod_reg[2*DW-1] ? sae_pkg::VAL_MIN : sae_pkg::VAL_MAX;
                end
            end
            sae_pkg::ACT_DIVRES:
            begin
                res_next = div_q;
            end
            sae_pkg::ACT_WB2:
            begin
                top_next   = res_reg;
                count_next = count_reg - CW'(1);
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        out_fin_next    = out_fin_reg;
        if (do_emit)
        begin
            out_valid_next  = 1'b1;
            out_top_next    = (count_reg == '0) ? '0 : top_reg;
            out_depth_next  = sae_pkg::DEPTH_W'(count_reg);
            out_status_next = ctl.uw.status;
            out_fin_next    = ctl.uw.fin;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        res_reg        <= res_next;
        prod_reg       <= prod_next;
        cval_reg       <= cval_next;
        out_top_reg    <= out_top_next;
        out_depth_reg  <= out_depth_next;
        out_status_reg <= out_status_next;
        out_fin_reg    <= out_fin_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_depth_reg, out_top_reg};
    assign m_tlast  = out_fin_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("transfer taken while busy");

    a_return_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[42:41] == sae_pkg::ST_OK))
        else $error("return reported a fault");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (act == sae_pkg::ACT_PUSH) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("push did not advance count");
`endif

endmodule

[bench/stack_arith_evaluator_core_tb.sv]
// ----------------------------------------------------------------------------
// stack_arith_evaluator_core_tb
// Self-checking bench for the Q16.16 stack evaluator. Instructions go in on
// the slave stream. A local model of the value stack predicts top, depth,
// status and the return flag for every transfer. Each result on the master
// stream is checked against the oldest prediction. Directed corner cases run
// first, then random programs under three source/sink stall mixes, then a
// fill to full depth and a reduction back down.
// ----------------------------------------------------------------------------
module stack_arith_evaluator_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STACK_N    = sae_pkg::STACK_DEPTH_DEF;
    localparam logic [2:0] KIND_SPARE = 3'd7;

    typedef struct packed {
        logic [31:0]                 top;
        logic [sae_pkg::DEPTH_W-1:0] depth;
        sae_pkg::status_t            status;
        logic                        fin;
    } eval_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // constant_value[31:0]
    logic [2:0]  s_tuser;    // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;    // top_value[31:0], depth[40:32], status[42:41], zero
    logic        m_tlast;

    logic [31:0]  op_stack [STACK_N];
    int           op_depth;
    int           peak_depth;
    eval_result_t pending_results[$];
    int           error_count;
    int           issued_count;
    int           status_count [4];
    int           src_idle_pct;
    int           sink_idle_pct;

    stack_arith_evaluator_core #(
        .STACK_DEPTH(STACK_N)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic logic [31:0] clamp_q16(input longint x);
        if (x > longint'($signed(sae_pkg::VAL_MAX)))
            return sae_pkg::VAL_MAX;
        if (x < longint'($signed(sae_pkg::VAL_MIN)))
            return sae_pkg::VAL_MIN;
        return x[31:0];
    endfunction

    function automatic eval_result_t execute_instr(input logic [2:0] k, input logic [31:0] v);
        eval_result_t     r;
        longint           a;
        longint           b;
        longint           q;
        sae_pkg::status_t st;
        st    = sae_pkg::ST_OK;
        r.fin = (k == sae_pkg::KIND_RET);
        case (k)
            sae_pkg::KIND_PUSH:
                if (op_depth >= STACK_N)
                    st = sae_pkg::ST_OVER;
                else
                begin
                    op_stack[op_depth] = v;
                    op_depth++;
                end
            sae_pkg::KIND_NEG:
                if (op_depth < 1)
                    st = sae_pkg::ST_UNDER;
                else
                begin
                    a = longint'($signed(op_stack[op_depth-1]));
                    op_stack[op_depth-1] = clamp_q16(-a);
                end
            sae_pkg::KIND_ADD, sae_pkg::KIND_SUB, sae_pkg::KIND_MUL, sae_pkg::KIND_DIV:
                if (op_depth < 2)
                    st = sae_pkg::ST_UNDER;
                else
                begin
                    a = longint'($signed(op_stack[op_depth-2]));
                    b = longint'($signed(op_stack[op_depth-1]));
                    if (k == sae_pkg::KIND_DIV && b == 0)
                        st = sae_pkg::ST_DIVZERO;
                    else
                    begin
                        case (k)
                            sae_pkg::KIND_ADD: q = a + b;
                            sae_pkg::KIND_SUB: q = a - b;
                            sae_pkg::KIND_MUL: q = (a * b) >>> 16;
                            default:           q = (a * 65536) / b;
                        endcase
                        op_stack[op_depth-2] = clamp_q16(q);
                        op_depth--;
                    end
                end
            default: ;
        endcase
        r.top    = (op_depth > 0) ? op_stack[op_depth-1] : '0;
        r.depth  = op_depth[sae_pkg::DEPTH_W-1:0];
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        int unsigned sel;
        logic [31:0] w;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        if (sel < 22)
        begin
            case ($urandom_range(5))
                0:       return sae_pkg::VAL_MAX;
                1:       return sae_pkg::VAL_MIN;
                2:       return 32'h0001_0000;
                3:       return 32'hFFFF_0000;
                4:       return 32'h0000_0001;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (sel < 65)
        begin
            w = $urandom_range(0, 32'h0010_0000);
            return w - 32'h0008_0000;
        end
        return $urandom;
    endfunction

    task automatic issue_instr(input logic [2:0] k, input logic [31:0] v);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(execute_instr(k, v));
        issued_count++;
        if (op_depth > peak_depth)
            peak_depth = op_depth;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_cases();
        issue_instr(sae_pkg::KIND_RET, '0);
        issue_instr(KIND_SPARE, 32'hFFFF_FFFF);
        issue_instr(sae_pkg::KIND_NEG, '0);
        issue_instr(sae_pkg::KIND_DIV, '0);
        issue_instr(sae_pkg::KIND_PUSH, sae_pkg::VAL_MAX);
        issue_instr(sae_pkg::KIND_ADD, '0);
        issue_instr(sae_pkg::KIND_PUSH, sae_pkg::VAL_MAX);
        issue_instr(sae_pkg::KIND_ADD, '0);
        issue_instr(sae_pkg::KIND_PUSH, sae_pkg::VAL_MIN);
        issue_instr(sae_pkg::KIND_NEG, '0);
        issue_instr(sae_pkg::KIND_PUSH, sae_pkg::VAL_MIN);
        issue_instr(sae_pkg::KIND_SUB, '0);
        issue_instr(sae_pkg::KIND_PUSH, sae_pkg::VAL_MIN);
        issue_instr(sae_pkg::KIND_MUL, '0);
        issue_instr(sae_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        issue_instr(sae_pkg::KIND_PUSH, 32'h0000_0001);
        issue_instr(sae_pkg::KIND_MUL, '0);
        issue_instr(sae_pkg::KIND_PUSH, '0);
        issue_instr(sae_pkg::KIND_DIV, '0);
        issue_instr(sae_pkg::KIND_PUSH, 32'hFFF9_0000);
        issue_instr(sae_pkg::KIND_PUSH, 32'h0002_0000);
        issue_instr(sae_pkg::KIND_DIV, '0);
        issue_instr(sae_pkg::KIND_PUSH, sae_pkg::VAL_MIN);
        issue_instr(sae_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        issue_instr(sae_pkg::KIND_DIV, '0);
        issue_instr(sae_pkg::KIND_RET, '0);
    endtask

    task automatic test_random_program(input int n);
        int         roll;
        logic [2:0] k;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                k = sae_pkg::KIND_RET;
            else if (roll < 6)
                k = KIND_SPARE;
            else if (roll < 12)
                k = 3'($urandom_range(sae_pkg::KIND_NEG, sae_pkg::KIND_DIV));
            else if (op_depth < 2 || (op_depth < 10 && roll < 50))
                k = sae_pkg::KIND_PUSH;
            else
                k = 3'($urandom_range(sae_pkg::KIND_NEG, sae_pkg::KIND_DIV));
            issue_instr(k, (k == sae_pkg::KIND_PUSH) ? pick_operand() : $urandom);
        end
    endtask

    task automatic test_deep_stack();
        while (op_depth < STACK_N)
            issue_instr(sae_pkg::KIND_PUSH, pick_operand());
        repeat (3)
            issue_instr(sae_pkg::KIND_PUSH, $urandom);
        issue_instr(sae_pkg::KIND_NEG, '0);
        issue_instr(sae_pkg::KIND_RET, '0);
        while (op_depth > 1)
            issue_instr(3'($urandom_range(sae_pkg::KIND_ADD, sae_pkg::KIND_DIV)), $urandom);
    endtask

    always @(posedge clk)
    begin : check_results
        eval_result_t want;
        logic [47:0]  want_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            status_count[m_tdata[42:41]]++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none pending, got data=%h last=%b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want      = pending_results.pop_front();
                want_word = {5'b0, want.status, want.depth, want.top};
                if (m_tdata !== want_word || m_tlast !== want.fin)
                begin
                    $display({"%0t: expected top=%h depth=%0d status=%0d last=%b, ",
                              "got top=%h depth=%0d status=%0d last=%b pad=%h"},
                             $time, want.top, want.depth, want.status, want.fin,
                             m_tdata[31:0], m_tdata[40:32], m_tdata[42:41], m_tlast,
                             m_tdata[47:43]);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("FAIL stack_arith_evaluator_core");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = sae_pkg::KIND_RET;
        op_depth      = 0;
        peak_depth    = 0;
        error_count   = 0;
        issued_count  = 0;
        status_count  = '{default: 0};
        src_idle_pct  = 19;
        sink_idle_pct = 86;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_program(340);
        wait_drained();

        src_idle_pct  = 86;
        sink_idle_pct = 19;
        test_random_program(340);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_program(340);
        test_deep_stack();
        wait_drained();

        repeat (40)
            @(posedge clk);
        $display("%0d instructions: %0d ok, %0d underflow, %0d overflow, %0d divide by zero",
                 issued_count, status_count[sae_pkg::ST_OK], status_count[sae_pkg::ST_UNDER],
                 status_count[sae_pkg::ST_OVER], status_count[sae_pkg::ST_DIVZERO]);
        $display("peak stack depth %0d of %0d, three stall mixes on both streams",
                 peak_depth, STACK_N);
        if (error_count == 0)
            $display("PASS stack_arith_evaluator_core");
        else
            $display("FAIL stack_arith_evaluator_core");
        $finish;
    end

endmodule
